### hdl/hidrd_pkg.sv
package hidrd_pkg;

   // default number of local usage slots
   localparam int USAGE_SLOTS_DEF = 8;

   // item prefix codes
   localparam logic [7:0] PFX_LONG_ITEM      = 8'hFE;
   localparam logic [7:0] TAG_MASK           = 8'hFC;
   localparam logic [7:0] TAG_USAGE_PAGE     = 8'h04;
   localparam logic [7:0] TAG_LOGICAL_MAX    = 8'h24;
   localparam logic [7:0] TAG_REPORT_SIZE    = 8'h74;
   localparam logic [7:0] TAG_REPORT_COUNT   = 8'h94;
   localparam logic [7:0] TAG_USAGE          = 8'h08;
   localparam logic [7:0] TAG_INPUT          = 8'h80;
   localparam logic [7:0] TAG_OUTPUT         = 8'h90;
   localparam logic [7:0] TAG_FEATURE        = 8'hB0;
   localparam logic [7:0] TAG_COLLECTION     = 8'hA0;
   localparam logic [7:0] TAG_END_COLLECTION = 8'hC0;

   // usage pages and usages of interest
   localparam logic [31:0] PAGE_GENERIC_DESKTOP = 32'h01;
   localparam logic [31:0] PAGE_BUTTON          = 32'h09;
   localparam logic [15:0] USAGE_X              = 16'h30;
   localparam logic [15:0] USAGE_Y              = 16'h31;

   // controller to datapath
   typedef struct packed {
      logic accept;       // take the presented descriptor word
      logic run;          // execute the collected item
      logic walk_step;    // examine one stored usage
      logic walk_finish;  // advance the bit offset, drop usages
      logic emit;         // load the result, clear the parser
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic run_now;      // the presented word completes an item
      logic is_input;     // the collected item is an Input item
      logic walk_more;    // another stored usage is to be examined
      logic out_free;     // the result register can take a new result
   } ctrl_status_type;

endpackage

### hdl/hidrd_req_if.sv
interface hidrd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] desc_byte;
   logic       last_byte;

   modport source (output valid, output desc_byte, output last_byte, input ready);
   modport sink   (input valid, input desc_byte, input last_byte, output ready);
endinterface

### hdl/hidrd_rsp_if.sv
interface hidrd_rsp_if;
   logic        valid;
   logic        ready;
   logic        button_found;
   logic [15:0] button_offset;
   logic        abs_found;
   logic [15:0] x_offset;
   logic [15:0] y_offset;
   logic [7:0]  abs_field_bits;
   logic [31:0] abs_logical_max;

   modport source (output valid, output button_found, output button_offset,
                   output abs_found, output x_offset, output y_offset,
                   output abs_field_bits, output abs_logical_max, input ready);
   modport sink   (input valid, input button_found, input button_offset,
                   input abs_found, input x_offset, input y_offset,
                   input abs_field_bits, input abs_logical_max, output ready);
endinterface

### hdl/hid_report_descriptor_parser_core.sv
// HID report descriptor parser. Feed the descriptor one word per handshake on
// req, with last_byte set on its final word; one result word then appears on
// rsp with the first button field offset and the absolute X/Y field layout,
// and the parser starts over for the next descriptor. Prefix, data and
// long-item words are accepted directly. The word that completes a short item
// is followed by a run step that executes it; an Input item then adds a usage
// walk over k stored usages (k at most USAGE_SLOTS), examined one per cycle,
// and a finish step. The final word is followed by an emit step that loads the
// result register and waits while an earlier result is still untaken; the
// register holds the result until taken while the next descriptor is already
// being accepted.
module hid_report_descriptor_parser_core #(
   parameter int USAGE_SLOTS = hidrd_pkg::USAGE_SLOTS_DEF
) (
   input logic         clock,
   input logic         reset,
   hidrd_req_if.sink   req,
   hidrd_rsp_if.source rsp
);

   hidrd_pkg::ctrl_cmd_type    cmd;
   hidrd_pkg::ctrl_status_type status;

   hidrd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_last  (req.last_byte),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   hidrd_dpath #(
      .USAGE_SLOTS (USAGE_SLOTS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .desc_byte (req.desc_byte),
      .last_byte (req.last_byte),
      .cmd       (cmd),
      .status    (status),
      .rsp       (rsp)
   );

endmodule

### hdl/hidrd_ctrl.sv
module hidrd_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_last,
   output logic                       req_ready,
   input  hidrd_pkg::ctrl_status_type status,
   output hidrd_pkg::ctrl_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_RUN  = 4'b0010,
      ST_WALK = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      last_ff, last_in;

   // where to go once an item has been executed
   state_type after_item;
   assign after_item = last_ff ? ST_EMIT : ST_IDLE;

   always_comb begin
      state_in = state_ff;
      last_in  = last_ff;
      cmd      = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               last_in    = req_last;
               if (status.run_now) begin
                  state_in = ST_RUN;
               end else if (req_last) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_RUN: begin
            cmd.run  = 1'b1;
            state_in = status.is_input ? ST_WALK : after_item;
         end
         ST_WALK: begin
            if (status.walk_more) begin
               cmd.walk_step = 1'b1;
            end else begin
               cmd.walk_finish = 1'b1;
               state_in        = after_item;
            end
         end
         ST_EMIT: begin
            // hold until the result register is free
            if (status.out_free) begin
               cmd.emit = 1'b1;
               last_in  = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
      end
   end

endmodule

### hdl/hidrd_dpath.sv
module hidrd_dpath #(
   parameter int USAGE_SLOTS = hidrd_pkg::USAGE_SLOTS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [7:0]                 desc_byte,
   input  logic                       last_byte,
   input  hidrd_pkg::ctrl_cmd_type    cmd,
   output hidrd_pkg::ctrl_status_type status,
   hidrd_rsp_if.source                rsp
);

   localparam int FILL_W = $clog2(USAGE_SLOTS + 1);
   localparam int IDX_W  = (USAGE_SLOTS > 1) ? $clog2(USAGE_SLOTS) : 1;
   localparam logic [FILL_W-1:0] SLOTS_CNT = FILL_W'(USAGE_SLOTS);

   typedef enum logic [1:0] {
      PH_PREFIX  = 2'd0,
      PH_DATA    = 2'd1,
      PH_LONGLEN = 2'd2,
      PH_SKIP    = 2'd3
   } phase_type;

   // byte framing
   phase_type   phase_ff, phase_in;
   logic [7:0]  prefix_ff, prefix_in;
   logic [31:0] data_ff, data_in;
   logic [2:0]  left_ff, left_in;
   logic [1:0]  idx_ff, idx_in;
   logic [8:0]  skip_ff, skip_in;
   // globals and running offset
   logic [31:0] page_ff, page_in;
   logic [31:0] lmax_ff, lmax_in;
   logic [31:0] rsize_ff, rsize_in;
   logic [31:0] rcount_ff, rcount_in;
   logic [31:0] bit_off_ff, bit_off_in;
   // local usages
   logic [15:0]       usage_slots_ff [USAGE_SLOTS];
   logic [FILL_W-1:0] fill_ff, fill_in;
   // usage walk
   logic [FILL_W-1:0] walk_f_ff, walk_f_in;
   logic [31:0]       walk_off_ff, walk_off_in;
   // collected findings
   logic        hbtn_found_ff, hbtn_found_in;
   logic [15:0] hbtn_off_ff, hbtn_off_in;
   logic        habs_found_ff, habs_found_in;
   logic [15:0] hx_off_ff, hx_off_in;
   logic [15:0] hy_off_ff, hy_off_in;
   logic [7:0]  habs_bits_ff, habs_bits_in;
   logic [31:0] habs_max_ff, habs_max_in;
   // result register
   logic        out_valid_ff, out_valid_in;
   logic        obtn_found_ff;
   logic [15:0] obtn_off_ff;
   logic        oabs_found_ff;
   logic [15:0] ox_off_ff;
   logic [15:0] oy_off_ff;
   logic [7:0]  oabs_bits_ff;
   logic [31:0] oabs_max_ff;

   logic [7:0]  tag;
   logic        run_now;
   logic [2:0]  n_bytes;
   logic [2:0]  left_dec;
   logic        abs_input;
   logic [15:0] slot_rd_ff;
   logic        usage_wr;
   logic [31:0] field_bits;

   assign tag        = prefix_ff & hidrd_pkg::TAG_MASK;
   assign field_bits = rsize_ff * rcount_ff;
   assign abs_input  = (data_ff[0] == 1'b0) && (data_ff[2] == 1'b0) &&
                       (page_ff == hidrd_pkg::PAGE_GENERIC_DESKTOP);
   assign usage_wr   = cmd.run && (tag == hidrd_pkg::TAG_USAGE) && (fill_ff < SLOTS_CNT);
   assign n_bytes    = (desc_byte[1:0] == 2'd3) ? 3'd4 : {1'b0, desc_byte[1:0]};
   assign left_dec   = (left_ff != 3'd0) ? left_ff - 3'd1 : 3'd0;

   // the presented word completes an item; a final word inside a short item
   // runs it with what has arrived
   assign run_now = ((phase_ff == PH_PREFIX) && (desc_byte != hidrd_pkg::PFX_LONG_ITEM) &&
                     ((n_bytes == 3'd0) || last_byte)) ||
                    ((phase_ff == PH_DATA) && ((left_dec == 3'd0) || last_byte));

   always_comb begin
      phase_in      = phase_ff;
      prefix_in     = prefix_ff;
      data_in       = data_ff;
      left_in       = left_ff;
      idx_in        = idx_ff;
      skip_in       = skip_ff;
      page_in       = page_ff;
      lmax_in       = lmax_ff;
      rsize_in      = rsize_ff;
      rcount_in     = rcount_ff;
      bit_off_in    = bit_off_ff;
      fill_in       = fill_ff;
      walk_f_in     = walk_f_ff;
      walk_off_in   = walk_off_ff;
      hbtn_found_in = hbtn_found_ff;
      hbtn_off_in   = hbtn_off_ff;
      habs_found_in = habs_found_ff;
      hx_off_in     = hx_off_ff;
      hy_off_in     = hy_off_ff;
      habs_bits_in  = habs_bits_ff;
      habs_max_in   = habs_max_ff;

      // frame the presented word
      unique case (phase_ff)
         PH_PREFIX: begin
            if (desc_byte == hidrd_pkg::PFX_LONG_ITEM) begin
               phase_in = PH_LONGLEN;
            end else begin
               prefix_in = desc_byte;
               data_in   = '0;
               idx_in    = 2'd0;
               left_in   = n_bytes;
               if (n_bytes != 3'd0) begin
                  phase_in = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            data_in = data_ff | (32'(desc_byte) << {idx_ff, 3'b000});
            idx_in  = idx_ff + 2'd1;
            left_in = left_dec;
            if (left_dec == 3'd0) begin
               phase_in = PH_PREFIX;
            end
         end
         PH_LONGLEN: begin
            skip_in  = 9'(desc_byte) + 9'd1;
            phase_in = PH_SKIP;
         end
         PH_SKIP: begin
            skip_in = (skip_ff != 9'd0) ? skip_ff - 9'd1 : 9'd0;
            if (skip_in == 9'd0) begin
               phase_in = PH_PREFIX;
            end
         end
         default: begin
            phase_in = PH_PREFIX;
         end
      endcase

      if (!cmd.accept) begin
         phase_in  = phase_ff;
         prefix_in = prefix_ff;
         data_in   = data_ff;
         left_in   = left_ff;
         idx_in    = idx_ff;
         skip_in   = skip_ff;
      end

      // execute the collected item
      if (cmd.run) begin
         unique case (tag)
            hidrd_pkg::TAG_USAGE_PAGE:   page_in   = data_ff;
            hidrd_pkg::TAG_LOGICAL_MAX:  lmax_in   = data_ff;
            hidrd_pkg::TAG_REPORT_SIZE:  rsize_in  = data_ff;
            hidrd_pkg::TAG_REPORT_COUNT: rcount_in = data_ff;
            hidrd_pkg::TAG_USAGE: begin
               if (usage_wr) begin
                  fill_in = fill_ff + FILL_W'(1);
               end
            end
            hidrd_pkg::TAG_INPUT: begin
               walk_f_in   = '0;
               walk_off_in = bit_off_ff;
               if ((data_ff[0] == 1'b0) && (page_ff == hidrd_pkg::PAGE_BUTTON) &&
                   !hbtn_found_ff) begin
                  hbtn_found_in = 1'b1;
                  hbtn_off_in   = bit_off_ff[15:0];
               end
            end
            hidrd_pkg::TAG_OUTPUT, hidrd_pkg::TAG_FEATURE,
            hidrd_pkg::TAG_COLLECTION, hidrd_pkg::TAG_END_COLLECTION: begin
               fill_in = '0;
            end
            default: begin
            end
         endcase
      end

      // examine one stored usage of an absolute desktop Input field
      if (cmd.walk_step) begin
         if (slot_rd_ff == hidrd_pkg::USAGE_X) begin
            hx_off_in     = walk_off_ff[15:0];
            habs_bits_in  = rsize_ff[7:0];
            habs_max_in   = lmax_ff;
            habs_found_in = 1'b1;
         end else if (slot_rd_ff == hidrd_pkg::USAGE_Y) begin
            hy_off_in = walk_off_ff[15:0];
         end
         walk_f_in   = walk_f_ff + FILL_W'(1);
         walk_off_in = walk_off_ff + rsize_ff;
      end

      // close the Input item
      if (cmd.walk_finish) begin
         bit_off_in = bit_off_ff + field_bits;
         fill_in    = '0;
      end

      // return the parser to its reset state after a result
      if (cmd.emit) begin
         phase_in      = PH_PREFIX;
         prefix_in     = '0;
         data_in       = '0;
         left_in       = '0;
         idx_in        = '0;
         skip_in       = '0;
         page_in       = '0;
         lmax_in       = '0;
         rsize_in      = '0;
         rcount_in     = '0;
         bit_off_in    = '0;
         fill_in       = '0;
         hbtn_found_in = 1'b0;
         hbtn_off_in   = '0;
         habs_found_in = 1'b0;
         hx_off_in     = '0;
         hy_off_in     = '0;
         habs_bits_in  = '0;
         habs_max_in   = '0;
      end
   end

   always_comb begin
      status.run_now   = run_now;
      status.is_input  = (tag == hidrd_pkg::TAG_INPUT);
      status.walk_more = abs_input && (walk_f_ff < fill_ff) &&
                         (32'(walk_f_ff) < rcount_ff);
      status.out_free  = !out_valid_ff || rsp.ready;
   end

   // drop the result once taken, raise it on emit
   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp.valid && rsp.ready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_PREFIX;
         prefix_ff     <= '0;
         data_ff       <= '0;
         left_ff       <= '0;
         idx_ff        <= '0;
         skip_ff       <= '0;
         page_ff       <= '0;
         lmax_ff       <= '0;
         rsize_ff      <= '0;
         rcount_ff     <= '0;
         bit_off_ff    <= '0;
         fill_ff       <= '0;
         walk_f_ff     <= '0;
         walk_off_ff   <= '0;
         hbtn_found_ff <= 1'b0;
         hbtn_off_ff   <= '0;
         habs_found_ff <= 1'b0;
         hx_off_ff     <= '0;
         hy_off_ff     <= '0;
         habs_bits_ff  <= '0;
         habs_max_ff   <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         prefix_ff     <= prefix_in;
         data_ff       <= data_in;
         left_ff       <= left_in;
         idx_ff        <= idx_in;
         skip_ff       <= skip_in;
         page_ff       <= page_in;
         lmax_ff       <= lmax_in;
         rsize_ff      <= rsize_in;
         rcount_ff     <= rcount_in;
         bit_off_ff    <= bit_off_in;
         fill_ff       <= fill_in;
         walk_f_ff     <= walk_f_in;
         walk_off_ff   <= walk_off_in;
         hbtn_found_ff <= hbtn_found_in;
         hbtn_off_ff   <= hbtn_off_in;
         habs_found_ff <= habs_found_in;
         hx_off_ff     <= hx_off_in;
         hy_off_ff     <= hy_off_in;
         habs_bits_ff  <= habs_bits_in;
         habs_max_ff   <= habs_max_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // store a local usage, low 16 bits of its data
   always_ff @(posedge clock) begin
      if (usage_wr) begin
         usage_slots_ff[fill_ff[IDX_W-1:0]] <= data_ff[15:0];
      end
   end

   // fetch the usage that the walk examines next
   always_ff @(posedge clock) begin
      slot_rd_ff <= usage_slots_ff[walk_f_in[IDX_W-1:0]];
   end

   // result payload
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         obtn_found_ff <= hbtn_found_ff;
         obtn_off_ff   <= hbtn_off_ff;
         oabs_found_ff <= habs_found_ff;
         ox_off_ff     <= hx_off_ff;
         oy_off_ff     <= hy_off_ff;
         oabs_bits_ff  <= habs_bits_ff;
         oabs_max_ff   <= habs_max_ff;
      end
   end

   assign rsp.valid           = out_valid_ff;
   assign rsp.button_found    = obtn_found_ff;
   assign rsp.button_offset   = obtn_off_ff;
   assign rsp.abs_found       = oabs_found_ff;
   assign rsp.x_offset        = ox_off_ff;
   assign rsp.y_offset        = oy_off_ff;
   assign rsp.abs_field_bits  = oabs_bits_ff;
   assign rsp.abs_logical_max = oabs_max_ff;

endmodule

### verif/tb_hid_report_descriptor_parser_core.sv
module tb_hid_report_descriptor_parser_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT   = 2000;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 24;
   localparam int PHASE_BYTES   = 210;

   // short item size codes, low two bits of a prefix
   localparam int SZ_0 = 0;
   localparam int SZ_1 = 1;
   localparam int SZ_2 = 2;
   localparam int SZ_4 = 3;

   // Input item flag bits
   localparam logic [31:0] IN_CONSTANT = 32'h01;
   localparam logic [31:0] IN_VARIABLE = 32'h02;
   localparam logic [31:0] IN_RELATIVE = 32'h04;

   typedef struct packed {
      logic        button_found;
      logic [15:0] button_offset;
      logic        abs_found;
      logic [15:0] x_offset;
      logic [15:0] y_offset;
      logic [7:0]  abs_field_bits;
      logic [31:0] abs_logical_max;
   } hid_summary_type;

   typedef enum logic [1:0] {
      SCAN_PREFIX,
      SCAN_DATA,
      SCAN_LONG_LEN,
      SCAN_SKIP
   } scan_phase_type;

   // Tracks the descriptor parse and holds the summaries still owed by the block.
   class hid_layout_board;
      scan_phase_type  phase;
      logic [7:0]      item_tag;
      logic [31:0]     item_value;
      logic [2:0]      data_left;
      logic [1:0]      data_pos;
      logic [8:0]      skip_left;
      logic [31:0]     page_now;
      logic [31:0]     lmax_now;
      logic [31:0]     size_now;
      logic [31:0]     count_now;
      logic [31:0]     bit_offset;
      logic [15:0]     usages [hidrd_pkg::USAGE_SLOTS_DEF];
      int unsigned     usage_count;
      hid_summary_type held;
      hid_summary_type summaries_due[$];
      int unsigned     mismatches;

      function new();
         mismatches = 0;
         restart();
      endfunction

      function void restart();
         phase       = SCAN_PREFIX;
         item_tag    = '0;
         item_value  = '0;
         data_left   = '0;
         data_pos    = '0;
         skip_left   = '0;
         page_now    = '0;
         lmax_now    = '0;
         size_now    = '0;
         count_now   = '0;
         bit_offset  = '0;
         usage_count = 0;
         held        = '0;
         foreach (usages[i]) usages[i] = '0;
      endfunction

      function int pending();
         return summaries_due.size();
      endfunction

      // Record the button block or walk the stored usages for X and Y.
      function void apply_input(logic [31:0] flags);
         logic [31:0] field_pos;
         int unsigned f;
         if (!flags[0]) begin
            if (page_now == hidrd_pkg::PAGE_BUTTON && !held.button_found) begin
               held.button_found  = 1'b1;
               held.button_offset = bit_offset[15:0];
            end else if (page_now == hidrd_pkg::PAGE_GENERIC_DESKTOP && !flags[2]) begin
               for (f = 0; f < usage_count; f++) begin
                  if (32'(f) >= count_now) break;
                  field_pos = bit_offset + 32'(f) * size_now;
                  if (usages[f] == hidrd_pkg::USAGE_X) begin
                     held.x_offset        = field_pos[15:0];
                     held.abs_field_bits  = size_now[7:0];
                     held.abs_logical_max = lmax_now;
                     held.abs_found       = 1'b1;
                  end else if (usages[f] == hidrd_pkg::USAGE_Y) begin
                     held.y_offset = field_pos[15:0];
                  end
               end
            end
         end
         bit_offset  = bit_offset + size_now * count_now;
         usage_count = 0;
      endfunction

      function void apply_item(logic [7:0] tag, logic [31:0] value);
         case (tag & hidrd_pkg::TAG_MASK)
            hidrd_pkg::TAG_USAGE_PAGE:   page_now  = value;
            hidrd_pkg::TAG_LOGICAL_MAX:  lmax_now  = value;
            hidrd_pkg::TAG_REPORT_SIZE:  size_now  = value;
            hidrd_pkg::TAG_REPORT_COUNT: count_now = value;
            hidrd_pkg::TAG_USAGE: begin
               if (usage_count < hidrd_pkg::USAGE_SLOTS_DEF) begin
                  usages[usage_count] = value[15:0];
                  usage_count++;
               end
            end
            hidrd_pkg::TAG_INPUT: apply_input(value);
            hidrd_pkg::TAG_OUTPUT, hidrd_pkg::TAG_FEATURE,
            hidrd_pkg::TAG_COLLECTION, hidrd_pkg::TAG_END_COLLECTION: usage_count = 0;
            default: ;
         endcase
      endfunction

      // Advance the parse by one accepted word.
      function void absorb_byte(logic [7:0] b, logic last);
         case (phase)
            SCAN_PREFIX: begin
               if (b == hidrd_pkg::PFX_LONG_ITEM) begin
                  phase = SCAN_LONG_LEN;
               end else begin
                  item_tag   = b;
                  item_value = '0;
                  data_pos   = '0;
                  data_left  = (b[1:0] == 2'd3) ? 3'd4 : {1'b0, b[1:0]};
                  if (data_left == 3'd0) apply_item(b, '0);
                  else phase = SCAN_DATA;
               end
            end
            SCAN_DATA: begin
               item_value = item_value | (32'(b) << (8 * data_pos));
               data_pos   = data_pos + 2'd1;
               if (data_left != 3'd0) data_left = data_left - 3'd1;
               if (data_left == 3'd0) begin
                  apply_item(item_tag, item_value);
                  phase = SCAN_PREFIX;
               end
            end
            SCAN_LONG_LEN: begin
               skip_left = 9'(b) + 9'd1;
               phase     = SCAN_SKIP;
            end
            default: begin
               if (skip_left != 9'd0) skip_left = skip_left - 9'd1;
               if (skip_left == 9'd0) phase = SCAN_PREFIX;
            end
         endcase
         // finish a cut-short item, then hand out the summary and start over
         if (last) begin
            if (phase == SCAN_DATA) apply_item(item_tag, item_value);
            summaries_due.push_back(held);
            restart();
         end
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      task compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want) report($sformatf("%s got %0h, want %0h", name, got, want));
      endtask

      task check_summary(hid_summary_type got);
         hid_summary_type want;
         if (summaries_due.size() == 0) begin
            report("result word with no descriptor outstanding");
            return;
         end
         want = summaries_due.pop_front();
         compare_field("button_found", 32'(got.button_found), 32'(want.button_found));
         compare_field("button_offset", 32'(got.button_offset), 32'(want.button_offset));
         compare_field("abs_found", 32'(got.abs_found), 32'(want.abs_found));
         compare_field("x_offset", 32'(got.x_offset), 32'(want.x_offset));
         compare_field("y_offset", 32'(got.y_offset), 32'(want.y_offset));
         compare_field("abs_field_bits", 32'(got.abs_field_bits), 32'(want.abs_field_bits));
         compare_field("abs_logical_max", got.abs_logical_max, want.abs_logical_max);
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   hidrd_req_if req_ch ();
   hidrd_rsp_if rsp_ch ();

   hid_report_descriptor_parser_core DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   hid_layout_board board;
   logic [7:0]      desc_q[$];
   int unsigned     sent_bytes     = 0;
   int unsigned     send_idle_pct  = 0;
   int unsigned     recv_stall_pct = 0;
   int unsigned     holds_asked    = 0;
   int unsigned     quiet_cycles   = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Note every accepted descriptor word.
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         board.absorb_byte(req_ch.desc_byte, req_ch.last_byte);
   end

   // Check every accepted result word.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         board.check_summary('{button_found:    rsp_ch.button_found,
                               button_offset:   rsp_ch.button_offset,
                               abs_found:       rsp_ch.abs_found,
                               x_offset:        rsp_ch.x_offset,
                               y_offset:        rsp_ch.y_offset,
                               abs_field_bits:  rsp_ch.abs_field_bits,
                               abs_logical_max: rsp_ch.abs_logical_max});
   end

   // Abort when nothing moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Drive ready at random; hold off for a long stretch when asked.
   initial begin
      int unsigned holds_done;
      holds_done   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (holds_done != holds_asked) begin
            holds_done   = holds_asked;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   function void put_short(logic [7:0] tag, logic [31:0] value, int code);
      int n;
      desc_q.push_back(tag | 8'(code));
      n = (code == SZ_4) ? 4 : code;
      for (int k = 0; k < n; k++) desc_q.push_back(8'(value >> (8 * k)));
   endfunction

   // Append a well-formed button block followed by an X/Y block.
   function void put_pointer_block();
      put_short(hidrd_pkg::TAG_USAGE_PAGE, hidrd_pkg::PAGE_BUTTON, SZ_1);
      put_short(hidrd_pkg::TAG_REPORT_COUNT, $urandom_range(1, 8), SZ_1);
      put_short(hidrd_pkg::TAG_REPORT_SIZE, 1, SZ_1);
      put_short(hidrd_pkg::TAG_INPUT, IN_VARIABLE, SZ_1);
      if ($urandom_range(1) != 0) put_short(hidrd_pkg::TAG_INPUT, IN_CONSTANT, SZ_1);
      put_short(hidrd_pkg::TAG_USAGE_PAGE, hidrd_pkg::PAGE_GENERIC_DESKTOP, SZ_1);
      if ($urandom_range(1) != 0) begin
         put_short(hidrd_pkg::TAG_USAGE, hidrd_pkg::USAGE_X, SZ_1);
         put_short(hidrd_pkg::TAG_USAGE, hidrd_pkg::USAGE_Y, SZ_1);
      end else begin
         put_short(hidrd_pkg::TAG_USAGE, hidrd_pkg::USAGE_Y, SZ_1);
         put_short(hidrd_pkg::TAG_USAGE, hidrd_pkg::USAGE_X, SZ_2);
      end
      put_short(hidrd_pkg::TAG_LOGICAL_MAX, $urandom,
                ($urandom_range(1) != 0) ? SZ_2 : SZ_4);
      put_short(hidrd_pkg::TAG_REPORT_SIZE, $urandom_range(1, 16), SZ_1);
      put_short(hidrd_pkg::TAG_REPORT_COUNT, $urandom_range(0, 3), SZ_1);
      put_short(hidrd_pkg::TAG_INPUT,
                ($urandom_range(3) == 0) ? (IN_VARIABLE | IN_RELATIVE) : IN_VARIABLE,
                SZ_1);
   endfunction

   // Append one item of random kind and content.
   function void put_random_item();
      int unsigned pick, k, len;
      logic [31:0] value;
      logic [7:0]  tag;
      pick = $urandom_range(99);
      if (pick < 12) begin
         k     = $urandom_range(9);
         value = (k < 5) ? hidrd_pkg::PAGE_GENERIC_DESKTOP :
                 (k < 8) ? hidrd_pkg::PAGE_BUTTON : $urandom;
         put_short(hidrd_pkg::TAG_USAGE_PAGE, value,
                   ($urandom_range(9) < 7) ? SZ_1 : $urandom_range(3));
      end else if (pick < 20) begin
         put_short(hidrd_pkg::TAG_LOGICAL_MAX, $urandom, $urandom_range(3));
      end else if (pick < 31) begin
         if ($urandom_range(9) < 8)
            put_short(hidrd_pkg::TAG_REPORT_SIZE, $urandom_range(16), SZ_1);
         else put_short(hidrd_pkg::TAG_REPORT_SIZE, $urandom, SZ_4);
      end else if (pick < 42) begin
         if ($urandom_range(9) < 8)
            put_short(hidrd_pkg::TAG_REPORT_COUNT, $urandom_range(10), SZ_1);
         else put_short(hidrd_pkg::TAG_REPORT_COUNT, $urandom, SZ_4);
      end else if (pick < 60) begin
         // a burst overflows the usage slots now and then
         len = ($urandom_range(9) == 0) ? $urandom_range(6, 11) : 1;
         repeat (len) begin
            k = $urandom_range(9);
            if (k < 3) put_short(hidrd_pkg::TAG_USAGE, hidrd_pkg::USAGE_X, SZ_1);
            else if (k < 6) put_short(hidrd_pkg::TAG_USAGE, hidrd_pkg::USAGE_Y, SZ_1);
            else if (k < 8)
               put_short(hidrd_pkg::TAG_USAGE,
                         ($urandom & 32'hFFFF_0000) | hidrd_pkg::USAGE_X, SZ_4);
            else put_short(hidrd_pkg::TAG_USAGE, $urandom, $urandom_range(3));
         end
      end else if (pick < 76) begin
         value = $urandom & (($urandom_range(1) != 0) ? ~(IN_CONSTANT | IN_RELATIVE) : '1);
         put_short(hidrd_pkg::TAG_INPUT, value,
                   ($urandom_range(9) < 7) ? SZ_1 : $urandom_range(3));
      end else if (pick < 84) begin
         k   = $urandom_range(3);
         tag = (k == 0) ? hidrd_pkg::TAG_OUTPUT : (k == 1) ? hidrd_pkg::TAG_FEATURE :
               (k == 2) ? hidrd_pkg::TAG_COLLECTION : hidrd_pkg::TAG_END_COLLECTION;
         put_short(tag, $urandom, $urandom_range(3));
      end else if (pick < 90) begin
         len = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(6);
         desc_q.push_back(hidrd_pkg::PFX_LONG_ITEM);
         desc_q.push_back(8'(len));
         repeat (len + 1) desc_q.push_back(8'($urandom));
      end else if (pick < 96) begin
         do tag = 8'($urandom); while (tag == hidrd_pkg::PFX_LONG_ITEM);
         put_short(tag & hidrd_pkg::TAG_MASK, $urandom, int'(tag[1:0]));
      end else begin
         desc_q.push_back(8'($urandom));
      end
   endfunction

   // Build a random descriptor, cut short now and then.
   function void build_random_descriptor();
      int unsigned n, keep;
      desc_q.delete();
      n = $urandom_range(1, 6);
      repeat (n) begin
         if ($urandom_range(99) < 25) put_pointer_block();
         else put_random_item();
      end
      if ($urandom_range(99) < 15 && desc_q.size() > 1) begin
         keep = $urandom_range(1, desc_q.size());
         while (desc_q.size() > keep) void'(desc_q.pop_back());
      end
   endfunction

   // Offer one word after any idle cycles; return on the edge that takes it.
   task send_byte(logic [7:0] b, logic last);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.desc_byte <= b;
      req_ch.last_byte <= last;
      do @(negedge clock); while (!req_ch.ready);
      @(posedge clock);
      sent_bytes++;
   endtask

   task send_descriptor();
      for (int i = 0; i < desc_q.size(); i++) send_byte(desc_q[i], i == desc_q.size() - 1);
   endtask

   // Drop valid and wait until every owed summary has come back.
   task wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   task run_random(int unsigned budget);
      int unsigned stop_at;
      stop_at = sent_bytes + budget;
      while (sent_bytes < stop_at) begin
         build_random_descriptor();
         send_descriptor();
      end
   endtask

   initial begin
      board            = new();
      req_ch.valid     = 1'b0;
      req_ch.desc_byte = '0;
      req_ch.last_byte = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // button block, then X/Y fields whose Input item is cut off by the last word
      desc_q.delete();
      put_short(hidrd_pkg::TAG_USAGE_PAGE, hidrd_pkg::PAGE_BUTTON, SZ_1);
      put_short(hidrd_pkg::TAG_REPORT_COUNT, 3, SZ_1);
      put_short(hidrd_pkg::TAG_REPORT_SIZE, 1, SZ_1);
      put_short(hidrd_pkg::TAG_INPUT, IN_VARIABLE, SZ_1);
      put_short(hidrd_pkg::TAG_USAGE_PAGE, hidrd_pkg::PAGE_GENERIC_DESKTOP, SZ_1);
      put_short(hidrd_pkg::TAG_USAGE, hidrd_pkg::USAGE_X, SZ_1);
      put_short(hidrd_pkg::TAG_USAGE, hidrd_pkg::USAGE_Y, SZ_1);
      put_short(hidrd_pkg::TAG_REPORT_COUNT, 2, SZ_1);
      put_short(hidrd_pkg::TAG_REPORT_SIZE, 16, SZ_1);
      put_short(hidrd_pkg::TAG_LOGICAL_MAX, 32'h0000_FFFF, SZ_4);
      desc_q.push_back(hidrd_pkg::TAG_INPUT | 8'(SZ_1));
      send_descriptor();

      // long item ended while its tag byte is being skipped
      desc_q.delete();
      desc_q.push_back(hidrd_pkg::PFX_LONG_ITEM);
      desc_q.push_back(8'h00);
      desc_q.push_back(8'h00);
      send_descriptor();

      // all-ones prefix alone: four-byte item with no data at all
      desc_q.delete();
      desc_q.push_back(8'hFF);
      send_descriptor();
      wait_drained();

      // random descriptors under four idling mixes
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
            default: begin send_idle_pct = 36; recv_stall_pct = 36; end
         endcase
         run_random(PHASE_BYTES);
         wait_drained();
         // back up the result side so the input stalls
         if (ph == 0) begin
            holds_asked++;
            repeat (6) begin
               desc_q.delete();
               put_random_item();
               send_descriptor();
            end
            wait_drained();
         end
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
